// ===== rtl/iee_pkg.sv =====
// Shared definitions for the infix expression evaluator.
// Character, operator, kind and status codes, and the divider request and response types.
// Depends on nothing.
`default_nettype none

package iee_pkg;

    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_LPAR  = 8'h28;
    localparam logic [7:0] CH_RPAR  = 8'h29;
    localparam logic [7:0] CH_LBRK  = 8'h5B;
    localparam logic [7:0] CH_RBRK  = 8'h5D;
    localparam logic [7:0] TEN      = 8'd10;

    localparam logic [2:0] OP_SENT = 3'd0;
    localparam logic [2:0] OP_ADD  = 3'd1;
    localparam logic [2:0] OP_SUB  = 3'd2;
    localparam logic [2:0] OP_MUL  = 3'd3;
    localparam logic [2:0] OP_DIV  = 3'd4;
    localparam logic [2:0] OP_LPAR = 3'd5;
    localparam logic [2:0] OP_LBRK = 3'd6;

    localparam logic [2:0] KIND_DIGIT  = 3'd0;
    localparam logic [2:0] KIND_ADDSUB = 3'd1;
    localparam logic [2:0] KIND_MULDIV = 3'd2;
    localparam logic [2:0] KIND_OPEN   = 3'd3;
    localparam logic [2:0] KIND_CLOSE  = 3'd4;
    localparam logic [2:0] KIND_END    = 3'd5;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_MALFORMED = 2'd1;
    localparam logic [1:0] ST_DIVZERO   = 2'd2;
    localparam logic [1:0] ST_OVERFLOW  = 2'd3;

    typedef struct packed {
        logic       start;
        logic [7:0] dividend;
        logic [7:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic       done;
        logic [7:0] quotient;
    } div_rsp_t;

    function automatic logic [2:0] sym_kind(input logic [7:0] c);
        logic [2:0] k;
        unique case (c) inside
            CH_PLUS, CH_MINUS:         k = KIND_ADDSUB;
            CH_STAR, CH_SLASH:         k = KIND_MULDIV;
            CH_LPAR, CH_LBRK:          k = KIND_OPEN;
            CH_RPAR, CH_RBRK:          k = KIND_CLOSE;
            CH_HASH:                   k = KIND_END;
            default:                   k = KIND_DIGIT;
        endcase
        return k;
    endfunction

    function automatic logic [2:0] sym_op(input logic [7:0] c);
        logic [2:0] op;
        unique case (c)
            CH_PLUS:  op = OP_ADD;
            CH_MINUS: op = OP_SUB;
            CH_STAR:  op = OP_MUL;
            CH_SLASH: op = OP_DIV;
            CH_LPAR:  op = OP_LPAR;
            CH_LBRK:  op = OP_LBRK;
            default:  op = OP_SENT;
        endcase
        return op;
    endfunction

    function automatic logic op_is_arith(input logic [2:0] op);
        return (op >= OP_ADD) && (op <= OP_DIV);
    endfunction

endpackage

`default_nettype wire

// ===== rtl/iee_mem.sv =====
// Synchronous single-port-write, single-port-read stack memory with registered read data.
// Depends on nothing.
`default_nettype none

module iee_mem #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== rtl/iee_div.sv =====
// Iterative 8-bit signed divider, one quotient bit per cycle, truncating toward zero.
// Depends on iee_pkg for the request and response types.
`default_nettype none

module iee_div (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire iee_pkg::div_req_t req,
    output iee_pkg::div_rsp_t      rsp
);

    import iee_pkg::*;

    logic       busy_reg, busy_next;
    logic [2:0] cnt_reg, cnt_next;
    logic       done_reg, done_next;
    logic       neg_reg, neg_next;
    logic [7:0] rem_reg, rem_next;
    logic [7:0] quo_reg, quo_next;
    logic [7:0] dvs_reg, dvs_next;

    logic [8:0] shifted;
    logic [9:0] diff;
    logic       take;

    always_comb
    begin
        shifted   = {rem_reg, quo_reg[7]};
        diff      = {1'b0, shifted} - {2'b00, dvs_reg};
        take      = !diff[9];
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        neg_next  = neg_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = 3'd7;
            neg_next  = req.dividend[7] ^ req.divisor[7];
            rem_next  = 8'd0;
            quo_next  = req.dividend[7] ? (~req.dividend + 8'd1) : req.dividend;
            dvs_next  = req.divisor[7] ? (~req.divisor + 8'd1) : req.divisor;
        end
        else if (busy_reg)
        begin
            rem_next = take ? diff[7:0] : shifted[7:0];
            quo_next = {quo_reg[6:0], take};
            cnt_next = cnt_reg - 3'd1;
            if (cnt_reg == 3'd0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= 3'd0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg <= neg_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = neg_reg ? (~quo_reg + 8'd1) : quo_reg;

endmodule

`default_nettype wire

// ===== rtl/infix_expression_evaluator.sv =====
// Infix expression evaluator: operator and operand stacks in two synchronous memories.
// A symbol is taken in IDLE and handled in EVAL; each + - * reduction passes through RED,
// and a divide by a nonzero divisor also waits in DIV for the divider. A closing bracket
// then pops its opener in POP; '#' presents its result once its reductions are done.
// Reset empties both stacks and seeds the sentinel; memory contents are not cleared.
// Depends on iee_pkg, iee_mem and iee_div.
`default_nettype none

module infix_expression_evaluator #(
    parameter int OPERATOR_DEPTH = 32,
    parameter int OPERAND_DEPTH  = 32
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              symbol_valid,
    output logic                   symbol_stall,
    input  wire logic [7:0]        symbol,
    output logic                   result_valid,
    input  wire logic              result_stall,
    output logic signed [7:0]      value,
    output logic        [1:0]      status
);

    import iee_pkg::*;

    localparam int OPC_W = $clog2(OPERATOR_DEPTH + 1);
    localparam int OPA_W = $clog2(OPERATOR_DEPTH);
    localparam int VLC_W = $clog2(OPERAND_DEPTH + 1);
    localparam int VLA_W = $clog2(OPERAND_DEPTH);

    localparam logic [OPC_W-1:0] OP_CNT_ONE  = OPC_W'(1);
    localparam logic [OPC_W-1:0] OP_CNT_TWO  = OPC_W'(2);
    localparam logic [OPC_W-1:0] OP_CNT_FULL = OPC_W'(OPERATOR_DEPTH);
    localparam logic [VLC_W-1:0] VL_CNT_ZERO = VLC_W'(0);
    localparam logic [VLC_W-1:0] VL_CNT_ONE  = VLC_W'(1);
    localparam logic [VLC_W-1:0] VL_CNT_TWO  = VLC_W'(2);
    localparam logic [VLC_W-1:0] VL_CNT_FULL = VLC_W'(OPERAND_DEPTH);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EVAL = 3'd1;
    localparam logic [2:0] S_RED  = 3'd2;
    localparam logic [2:0] S_POP  = 3'd3;
    localparam logic [2:0] S_DIV  = 3'd4;

    logic [2:0]       state_reg, state_next;
    logic [7:0]       sym_reg, sym_next;
    logic [OPC_W-1:0] op_cnt_reg, op_cnt_next;
    logic [2:0]       op_top_reg, op_top_next;
    logic [VLC_W-1:0] val_cnt_reg, val_cnt_next;
    logic [7:0]       val_top_reg, val_top_next;
    logic             prev_digit_reg, prev_digit_next;
    logic [1:0]       err_reg, err_next;
    logic             res_valid_reg, res_valid_next;
    logic [7:0]       res_value_reg, res_value_next;
    logic [1:0]       res_status_reg, res_status_next;

    logic             op_we;
    logic [OPA_W-1:0] op_waddr, op_raddr;
    logic [2:0]       op_rdata;
    logic             val_we;
    logic [VLA_W-1:0] val_waddr, val_raddr;
    logic [7:0]       val_rdata;
    logic [OPC_W-1:0] op_cnt_m1, op_cnt_m2;
    logic [VLC_W-1:0] val_cnt_m1, val_cnt_m2;

    div_req_t div_req;
    div_rsp_t div_rsp;

    logic [2:0]  kind;
    logic [7:0]  digit;
    logic        reduce_now;
    logic [2:0]  want;
    logic [7:0]  a_v, b_v;
    logic [15:0] prod;
    logic [15:0] ext_prod;
    logic        out_free;
    logic [1:0]  final_status;

    assign op_cnt_m1  = op_cnt_reg - OP_CNT_ONE;
    assign op_cnt_m2  = op_cnt_reg - OP_CNT_TWO;
    assign val_cnt_m1 = val_cnt_reg - VL_CNT_ONE;
    assign val_cnt_m2 = val_cnt_reg - VL_CNT_TWO;
    assign op_waddr   = op_cnt_m1[OPA_W-1:0];
    assign op_raddr   = op_cnt_m2[OPA_W-1:0];
    assign val_waddr  = val_cnt_m1[VLA_W-1:0];
    assign val_raddr  = val_cnt_m2[VLA_W-1:0];

    iee_mem #(
        .WIDTH (3),
        .DEPTH (OPERATOR_DEPTH)
    ) u_op_mem (
        .clk   (clk),
        .we    (op_we),
        .waddr (op_waddr),
        .wdata (op_top_reg),
        .raddr (op_raddr),
        .rdata (op_rdata)
    );

    iee_mem #(
        .WIDTH (8),
        .DEPTH (OPERAND_DEPTH)
    ) u_val_mem (
        .clk   (clk),
        .we    (val_we),
        .waddr (val_waddr),
        .wdata (val_top_reg),
        .raddr (val_raddr),
        .rdata (val_rdata)
    );

    iee_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    always_comb
    begin
        state_next      = state_reg;
        sym_next        = sym_reg;
        op_cnt_next     = op_cnt_reg;
        op_top_next     = op_top_reg;
        val_cnt_next    = val_cnt_reg;
        val_top_next    = val_top_reg;
        prev_digit_next = prev_digit_reg;
        err_next        = err_reg;
        res_valid_next  = res_valid_reg && result_stall;
        res_value_next  = res_value_reg;
        res_status_next = res_status_reg;
        op_we           = 1'b0;
        val_we          = 1'b0;
        div_req         = '0;

        kind       = sym_kind(sym_reg);
        digit      = sym_reg - CH_ZERO;
        reduce_now = op_is_arith(op_top_reg)
                     && (kind == KIND_ADDSUB || kind == KIND_CLOSE || kind == KIND_END
                         || (kind == KIND_MULDIV && op_top_reg >= OP_MUL));
        want       = (sym_reg == CH_RPAR) ? OP_LPAR : OP_LBRK;
        b_v        = (val_cnt_reg != VL_CNT_ZERO) ? val_top_reg : 8'd0;
        a_v        = (val_cnt_reg >= VL_CNT_TWO) ? val_rdata : 8'd0;
        prod       = a_v * b_v;
        ext_prod   = val_top_reg * TEN;
        out_free   = !res_valid_reg || !result_stall;

        final_status = err_reg;
        if (err_reg == ST_OK && (op_top_reg != OP_SENT || val_cnt_reg != VL_CNT_ONE))
        begin
            final_status = ST_MALFORMED;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (symbol_valid)
                begin
                    sym_next   = symbol;
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                if (kind == KIND_DIGIT)
                begin
                    if (prev_digit_reg && val_cnt_reg != VL_CNT_ZERO)
                    begin
                        val_top_next = ext_prod[7:0] + digit;
                    end
                    else if (val_cnt_reg != VL_CNT_FULL)
                    begin
                        val_we       = (val_cnt_reg != VL_CNT_ZERO);
                        val_top_next = digit;
                        val_cnt_next = val_cnt_reg + VL_CNT_ONE;
                    end
                    else if (err_reg == ST_OK)
                    begin
                        err_next = ST_OVERFLOW;
                    end
                    prev_digit_next = (sym_reg >= CH_ZERO) && (sym_reg <= CH_NINE);
                    state_next      = S_IDLE;
                end
                else if (reduce_now)
                begin
                    prev_digit_next = 1'b0;
                    state_next      = S_RED;
                end
                else
                begin
                    prev_digit_next = 1'b0;
                    state_next      = S_IDLE;
                    case (kind)
                        KIND_CLOSE:
                        begin
                            if (op_top_reg == want && op_cnt_reg > OP_CNT_ONE)
                            begin
                                op_cnt_next = op_cnt_m1;
                                state_next  = S_POP;
                            end
                            else if (err_reg == ST_OK)
                            begin
                                err_next = ST_MALFORMED;
                            end
                        end
                        KIND_END:
                        begin
                            if (out_free)
                            begin
                                res_valid_next  = 1'b1;
                                res_value_next  = (val_cnt_reg != VL_CNT_ZERO) ? val_top_reg
                                                                               : 8'd0;
                                res_status_next = final_status;
                                op_cnt_next     = OP_CNT_ONE;
                                op_top_next     = OP_SENT;
                                val_cnt_next    = VL_CNT_ZERO;
                                err_next        = ST_OK;
                            end
                            else
                            begin
                                state_next = S_EVAL;
                            end
                        end
                        default:
                        begin
                            if (op_cnt_reg != OP_CNT_FULL)
                            begin
                                op_we       = 1'b1;
                                op_top_next = sym_op(sym_reg);
                                op_cnt_next = op_cnt_reg + OP_CNT_ONE;
                            end
                            else if (err_reg == ST_OK)
                            begin
                                err_next = ST_OVERFLOW;
                            end
                        end
                    endcase
                end
            end
            S_RED:
            begin
                op_cnt_next  = op_cnt_m1;
                op_top_next  = (op_cnt_m1 == OP_CNT_ONE) ? OP_SENT : op_rdata;
                val_cnt_next = (val_cnt_reg < VL_CNT_TWO) ? VL_CNT_ONE : val_cnt_m1;
                if (err_reg == ST_OK)
                begin
                    if (val_cnt_reg < VL_CNT_TWO)
                    begin
                        err_next = ST_MALFORMED;
                    end
                    else if (op_top_reg == OP_DIV && b_v == 8'd0)
                    begin
                        err_next = ST_DIVZERO;
                    end
                end
                state_next = S_EVAL;
                case (op_top_reg)
                    OP_ADD: val_top_next = a_v + b_v;
                    OP_SUB: val_top_next = a_v - b_v;
                    OP_MUL: val_top_next = prod[7:0];
                    default:
                    begin
                        if (b_v == 8'd0)
                        begin
                            val_top_next = 8'd0;
                        end
                        else
                        begin
                            div_req.start    = 1'b1;
                            div_req.dividend = a_v;
                            div_req.divisor  = b_v;
                            state_next       = S_DIV;
                        end
                    end
                endcase
            end
            S_POP:
            begin
                op_top_next = (op_cnt_reg == OP_CNT_ONE) ? OP_SENT : op_rdata;
                state_next  = S_IDLE;
            end
            S_DIV:
            begin
                if (div_rsp.done)
                begin
                    val_top_next = div_rsp.quotient;
                    state_next   = S_EVAL;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            op_cnt_reg     <= OP_CNT_ONE;
            op_top_reg     <= OP_SENT;
            val_cnt_reg    <= VL_CNT_ZERO;
            prev_digit_reg <= 1'b0;
            err_reg        <= ST_OK;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            op_cnt_reg     <= op_cnt_next;
            op_top_reg     <= op_top_next;
            val_cnt_reg    <= val_cnt_next;
            prev_digit_reg <= prev_digit_next;
            err_reg        <= err_next;
            res_valid_reg  <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sym_reg        <= sym_next;
        val_top_reg    <= val_top_next;
        res_value_reg  <= res_value_next;
        res_status_reg <= res_status_next;
    end

    assign symbol_stall = (state_reg != S_IDLE);
    assign result_valid = res_valid_reg;
    assign value        = res_value_reg;
    assign status       = res_status_reg;

    a_op_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        (op_cnt_reg != '0) && (op_cnt_reg <= OP_CNT_FULL))
        else $error("operator count out of range");

    a_val_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        val_cnt_reg <= VL_CNT_FULL)
        else $error("operand count out of range");

    a_sentinel_top: assert property (@(posedge clk) disable iff (!rst_n)
        (op_cnt_reg == OP_CNT_ONE && state_reg != S_POP) |-> (op_top_reg == OP_SENT))
        else $error("empty operator stack does not show the sentinel");

    a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> (state_reg == S_DIV))
        else $error("divider finished outside the divide wait");

    a_accept_eval: assert property (@(posedge clk) disable iff (!rst_n)
        (symbol_valid && !symbol_stall) |=> (state_reg == S_EVAL))
        else $error("accepted request was not evaluated");

endmodule

`default_nettype wire
